// File: hdl/assert_macros.svh
// Assertion macros used by the top-level decoder of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds at a clock edge, cons must hold at that same edge.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The condition must never be true at a clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

`endif

// File: hdl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types and character constants for the URL percent decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package upd_pkg;

  localparam logic [7:0] CHR_PLUS    = 8'h2B;
  localparam logic [7:0] CHR_PERCENT = 8'h25;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_LOW_A   = 8'h61;
  localparam logic [7:0] CHR_LOW_F   = 8'h66;
  localparam logic [7:0] CHR_UP_A    = 8'h41;
  localparam logic [7:0] CHR_UP_F    = 8'h46;

  // Maximum number of decoded bytes that one input word can produce.
  localparam int unsigned MaxOut = 3;
  localparam int unsigned CntW   = $clog2(MaxOut + 1);

  // Queue between the classifier and the output sequencer.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One classified input word: the decoded bytes it produces, in order.
  typedef struct packed {
    logic [CntW-1:0]           cnt;
    logic [MaxOut-1:0][7:0]    data;
    logic                      last;
  } plan_t;

endpackage

// File: hdl/url_percent_decoder.sv
// Path: an accepted word's plan is queued, then each byte is registered in the output stage.
// Throughput: one input word per cycle while the plan queue is not full; a word that decodes
// to k bytes holds the output sequencer for each of its k bytes, and a two-entry plan queue absorbs the difference.
// Reset: rst_ni clears the escape state, the queue and the output stage asynchronously.
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming decoder for form-URL encoding: '+' to space, %XX to one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module url_percent_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_end_o,
  output logic       out_valid_o,
  input  logic       out_stall_i
);

  upd_pkg::plan_t plan, head;
  logic           push, pop, q_full, head_valid;

  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .plan_o     (plan)
  );

  upd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .plan_i       (plan),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  upd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i)
  );

  // The end of a string always produces at least one decoded word.
  `ASSERT_IMPLIES(a_last_pushes, clk_i, rst_ni, in_valid_i && !in_stall_o && in_last_i, push)
  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push && q_full && !pop)
  `ASSERT_IMPLIES(a_pop_nonempty, clk_i, rst_ni, pop, head_valid)
  `ASSERT_IMPLIES(a_end_is_run_last, clk_i, rst_ni, out_valid_o && string_end_o, run_last_o)

endmodule

// File: hdl/upd_front.sv
// ----------------------------------------------------------------------------
// upd_front
// Accepts encoded bytes, tracks the escape state and turns each word into
// a plan of up to three decoded bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     in_byte_i,
  input  logic           in_last_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           q_full_i,
  output logic           push_o,
  output upd_pkg::plan_t plan_o
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       accept;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = ((c >= upd_pkg::CHR_ZERO)  && (c <= upd_pkg::CHR_NINE))  ||
             ((c >= upd_pkg::CHR_LOW_A) && (c <= upd_pkg::CHR_LOW_F)) ||
             ((c >= upd_pkg::CHR_UP_A)  && (c <= upd_pkg::CHR_UP_F));
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c <= upd_pkg::CHR_NINE) begin
      v = c - upd_pkg::CHR_ZERO;
    end else if (c >= upd_pkg::CHR_LOW_A) begin
      v = c - upd_pkg::CHR_LOW_A + 8'd10;
    end else begin
      v = c - upd_pkg::CHR_UP_A + 8'd10;
    end
    nibble = v[3:0];
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    logic                           hex;
    logic                           do_fresh;
    logic [upd_pkg::CntW-1:0]       cnt;
    logic [upd_pkg::MaxOut-1:0][7:0] data;

    hex      = is_hex(in_byte_i);
    do_fresh = 1'b0;
    cnt      = '0;
    data     = '0;
    phase_d  = phase_q;
    held_d   = held_q;

    unique case (phase_q)
      PH_PCT: begin
        if (hex) begin
          held_d  = in_byte_i;
          phase_d = PH_DIGIT;
        end else begin
          data[cnt[1:0]] = upd_pkg::CHR_PERCENT;
          cnt            = cnt + 1'b1;
          phase_d        = PH_IDLE;
          do_fresh       = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (hex) begin
          data[cnt[1:0]] = {nibble(held_q), nibble(in_byte_i)};
          cnt            = cnt + 1'b1;
        end else begin
          data[cnt[1:0]] = upd_pkg::CHR_PERCENT;
          cnt            = cnt + 1'b1;
          data[cnt[1:0]] = held_q;
          cnt            = cnt + 1'b1;
          do_fresh       = 1'b1;
        end
        phase_d = PH_IDLE;
        held_d  = '0;
      end
      default: begin
        phase_d  = PH_IDLE;
        do_fresh = 1'b1;
      end
    endcase

    if (do_fresh) begin
      if (in_byte_i == upd_pkg::CHR_PLUS) begin
        data[cnt[1:0]] = upd_pkg::CHR_SPACE;
        cnt            = cnt + 1'b1;
      end else if (in_byte_i == upd_pkg::CHR_PERCENT) begin
        phase_d = PH_PCT;
      end else begin
        data[cnt[1:0]] = in_byte_i;
        cnt            = cnt + 1'b1;
      end
    end

    // At the end of the string a pending escape goes out literally.
    if (in_last_i) begin
      if (phase_d == PH_PCT) begin
        data[cnt[1:0]] = upd_pkg::CHR_PERCENT;
        cnt            = cnt + 1'b1;
      end else if (phase_d == PH_DIGIT) begin
        data[cnt[1:0]] = upd_pkg::CHR_PERCENT;
        cnt            = cnt + 1'b1;
        data[cnt[1:0]] = held_d;
        cnt            = cnt + 1'b1;
      end
      phase_d = PH_IDLE;
      held_d  = '0;
    end

    plan_o.cnt  = cnt;
    plan_o.data = data;
    plan_o.last = in_last_i;
  end

  assign push_o = accept && (plan_o.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// File: hdl/upd_queue.sv
// ----------------------------------------------------------------------------
// upd_queue
// Short queue of decoded-byte plans between the classifier and the
// output sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  upd_pkg::plan_t plan_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output upd_pkg::plan_t head_o
);

  upd_pkg::plan_t              mem_q [upd_pkg::QDepth];
  logic [upd_pkg::QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [upd_pkg::QCntW-1:0]   count_q;

  assign full_o       = (count_q == upd_pkg::QCntW'(upd_pkg::QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= plan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/upd_back.sv
// ----------------------------------------------------------------------------
// upd_back
// Output sequencer: sends the bytes of each plan one word per cycle, unless
// out_stall_i holds it, through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  upd_pkg::plan_t head_i,
  output logic           pop_o,
  output logic [7:0]     out_byte_o,
  output logic           run_last_o,
  output logic           string_end_o,
  output logic           out_valid_o,
  input  logic           out_stall_i
);

  upd_pkg::plan_t            cur_q;
  logic [upd_pkg::CntW-1:0]  idx_q;
  logic                      busy_q;
  logic                      out_valid_q;
  logic [7:0]                out_byte_q;
  logic                      run_last_q, string_end_q;
  logic                      adv;
  logic                      cur_fin, head_fin;

  assign adv      = !out_valid_q || !out_stall_i;
  assign pop_o    = adv && !busy_q && head_valid_i;
  assign cur_fin  = (idx_q == cur_q.cnt - 1'b1);
  assign head_fin = (head_i.cnt == upd_pkg::CntW'(1));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (busy_q) begin
        out_byte_q   <= cur_q.data[idx_q[1:0]];
        run_last_q   <= cur_fin;
        string_end_q <= cur_fin && cur_q.last;
      end else if (head_valid_i) begin
        out_byte_q   <= head_i.data[0];
        run_last_q   <= head_fin;
        string_end_q <= head_fin && head_i.last;
        cur_q        <= head_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      if (busy_q) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_q + 1'b1;
        busy_q      <= !cur_fin;
      end else if (head_valid_i) begin
        out_valid_q <= 1'b1;
        idx_q       <= upd_pkg::CntW'(1);
        busy_q      <= !head_fin;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_byte_o   = out_byte_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = string_end_q;
  assign out_valid_o  = out_valid_q;

endmodule

// File: test/tb_url_percent_decoder.sv
// ----------------------------------------------------------------------------
// tb_url_percent_decoder
// Self-checking bench for the form-URL decoder. A clocked driver feeds encoded
// strings from a queue of pending words, and a behavioral decoder predicts the
// decoded bytes of every accepted word. A clocked monitor compares each decoded
// word with the oldest prediction. Both sides idle at random, and the receiver
// also holds off for one long stretch so that the decoder backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_url_percent_decoder;

  localparam int unsigned NumWords = 330;
  localparam int unsigned CycLimit = 200000;
  localparam int unsigned HoldAt   = 150;
  localparam int unsigned HoldLen  = 80;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PCT,
    PH_DIGIT
  } esc_phase_e;

  typedef struct {
    logic [7:0] chr;
    logic       last;
    bit         drain;
  } enc_word_t;

  typedef struct {
    logic [7:0]      chr;
    logic            run_last;
    logic            str_end;
    longint unsigned stamp;
  } dec_word_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic [7:0] in_byte_i    = 8'h00;
  logic       in_last_i    = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       string_end_o;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;

  enc_word_t  enc_pending[$];
  dec_word_t  dec_expected[$];

  esc_phase_e esc_phase = PH_IDLE;
  logic [7:0] held_digit = 8'h00;

  int unsigned n_sent     = 0;
  int unsigned n_strings  = 0;
  int unsigned n_checked  = 0;
  int unsigned n_broken   = 0;
  int unsigned n_err      = 0;
  int unsigned cyc        = 0;
  int unsigned tx_gap     = 0;
  int unsigned rx_idle    = 0;
  bit          tx_quiet   = 1'b0;
  bit          rx_quiet   = 1'b0;
  logic        rx_hold    = 1'b0;

  url_percent_decoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit is_hex(logic [7:0] c);
    return (c >= upd_pkg::CHR_ZERO && c <= upd_pkg::CHR_NINE) ||
           (c >= upd_pkg::CHR_LOW_A && c <= upd_pkg::CHR_LOW_F) ||
           (c >= upd_pkg::CHR_UP_A && c <= upd_pkg::CHR_UP_F);
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    logic [7:0] d;
    if (c <= upd_pkg::CHR_NINE) begin
      d = c - upd_pkg::CHR_ZERO;
    end else if (c >= upd_pkg::CHR_LOW_A) begin
      d = c - upd_pkg::CHR_LOW_A + 8'd10;
    end else begin
      d = c - upd_pkg::CHR_UP_A + 8'd10;
    end
    return d[3:0];
  endfunction

  // Works out the decoded bytes that one accepted encoded word completes.
  function automatic void decode_word(logic [7:0] b, logic last);
    logic [7:0] outs[$];
    bit         taken;
    dec_word_t  w;
    taken = 1'b0;
    case (esc_phase)
      PH_PCT: begin
        if (is_hex(b)) begin
          held_digit = b;
          esc_phase  = PH_DIGIT;
          taken      = 1'b1;
        end else begin
          outs.push_back(upd_pkg::CHR_PERCENT);
          esc_phase = PH_IDLE;
          n_broken++;
        end
      end
      PH_DIGIT: begin
        if (is_hex(b)) begin
          outs.push_back({hex_nibble(held_digit), hex_nibble(b)});
          taken = 1'b1;
        end else begin
          outs.push_back(upd_pkg::CHR_PERCENT);
          outs.push_back(held_digit);
          n_broken++;
        end
        esc_phase  = PH_IDLE;
        held_digit = 8'h00;
      end
      default: esc_phase = PH_IDLE;
    endcase
    // A byte that broke an escape is decoded again from the idle phase.
    if (!taken) begin
      if (b == upd_pkg::CHR_PLUS) begin
        outs.push_back(upd_pkg::CHR_SPACE);
      end else if (b == upd_pkg::CHR_PERCENT) begin
        esc_phase = PH_PCT;
      end else begin
        outs.push_back(b);
      end
    end
    if (last) begin
      if (esc_phase == PH_PCT) begin
        outs.push_back(upd_pkg::CHR_PERCENT);
      end else if (esc_phase == PH_DIGIT) begin
        outs.push_back(upd_pkg::CHR_PERCENT);
        outs.push_back(held_digit);
      end
      esc_phase  = PH_IDLE;
      held_digit = 8'h00;
    end
    foreach (outs[i]) begin
      w.chr      = outs[i];
      w.run_last = (i == outs.size() - 1);
      w.str_end  = (i == outs.size() - 1) && last;
      w.stamp    = $time;
      dec_expected.push_back(w);
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_word(logic [7:0] c, logic last, bit drain);
    enc_word_t e;
    e.chr   = c;
    e.last  = last;
    e.drain = drain;
    enc_pending.push_back(e);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) begin
      push_word(s[i], i == s.len() - 1, 1'b0);
    end
  endfunction

  // Driver: offers the next pending word once the previous one is taken.
  always @(posedge clk_i) begin
    logic       nv;
    logic [7:0] nb;
    logic       nl;
    enc_word_t  e;
    nv = in_valid_i;
    nb = in_byte_i;
    nl = in_last_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_word(in_byte_i, in_last_i);
        n_sent++;
        if (in_last_i) n_strings++;
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
        tx_gap = tx_quiet ? 0 : pick_gap();
        nv = 1'b0;
      end
      if (!nv) begin
        if (rx_hold) tx_gap = 0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (enc_pending.size() > 0 &&
                     (!enc_pending[0].drain || dec_expected.size() == 0)) begin
          e  = enc_pending.pop_front();
          nv = 1'b1;
          nb = e.chr;
          nl = e.last;
        end
      end
    end
    in_valid_i <= nv;
    in_byte_i  <= nb;
    in_last_i  <= nl;
  end

  // Long receiver hold-off while the driver keeps offering words.
  initial begin
    while (n_sent < HoldAt) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldLen) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Monitor: checks each accepted decoded word against the oldest prediction.
  always @(posedge clk_i) begin
    dec_word_t w;
    bit        stall;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        // A prediction made at this very edge cannot belong to this word.
        if (dec_expected.size() == 0 || dec_expected[0].stamp == $time) begin
          $error("out_byte: no decoded word expected, actual %02h", out_byte_o);
          n_err++;
        end else begin
          w = dec_expected.pop_front();
          n_checked++;
          if (out_byte_o !== w.chr) begin
            $error("out_byte: expected %02h, actual %02h", w.chr, out_byte_o);
            n_err++;
          end
          if (run_last_o !== w.run_last) begin
            $error("run_last: expected %0b, actual %0b", w.run_last, run_last_o);
            n_err++;
          end
          if (string_end_o !== w.str_end) begin
            $error("string_end: expected %0b, actual %0b", w.str_end, string_end_o);
            n_err++;
          end
        end
      end
      if ($urandom_range(0, 99) == 0) rx_quiet = !rx_quiet;
      if (rx_idle == 0 && !rx_quiet && $urandom_range(0, 3) == 0) rx_idle = pick_gap();
      stall = 1'b0;
      if (rx_idle > 0) begin
        stall = 1'b1;
        rx_idle--;
      end
      out_stall_i <= stall || rx_hold;
    end
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc >= CycLimit) begin
      $display("url_percent_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    string      hexd;
    logic [7:0] s[$];
    int unsigned len;
    int unsigned r;
    bit         drain;
    hexd = "0123456789abcdefABCDEF";

    // Directed: byte extremes, '+', good escapes in both cases, escapes broken
    // after '%' and after one digit, and every kind of flush at the string end.
    push_word(8'h00, 1'b0, 1'b0);
    push_word(8'hFF, 1'b1, 1'b0);
    push_str("+%4a%F0");
    push_str("%G%b+");
    push_str("%%");
    push_str("%A%");
    push_str("%");
    push_str("%9");

    // Random strings, mostly well formed with some broken escapes and noise.
    while (enc_pending.size() < NumWords) begin
      s.delete();
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 8);
      while (s.size() < len) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          s.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end else if (r < 50) begin
          s.push_back(upd_pkg::CHR_PLUS);
        end else if (r < 80) begin
          s.push_back(upd_pkg::CHR_PERCENT);
          s.push_back(hexd[$urandom_range(0, 21)]);
          s.push_back(hexd[$urandom_range(0, 21)]);
        end else if (r < 90) begin
          s.push_back(upd_pkg::CHR_PERCENT);
          s.push_back(hexd[$urandom_range(0, 21)]);
          s.push_back(8'($urandom_range(0, 255)));
        end else if (r < 95) begin
          s.push_back(upd_pkg::CHR_PERCENT);
          s.push_back(8'($urandom_range(0, 255)));
        end else begin
          s.push_back(8'($urandom_range(0, 255)));
        end
      end
      drain = ($urandom_range(0, 11) == 0) ||
              (enc_pending.size() >= 200 && enc_pending.size() < 200 + len);
      foreach (s[i]) push_word(s[i], i == s.size() - 1, drain && i == 0);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (enc_pending.size() > 0 || in_valid_i || dec_expected.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d encoded words in %0d strings, %0d broken escapes",
             n_sent, n_strings, n_broken);
    $display("checked %0d decoded words with random stalls and one long hold-off",
             n_checked);
    if (n_err == 0 && dec_expected.size() == 0) begin
      $display("url_percent_decoder regression: pass");
    end else begin
      $display("url_percent_decoder regression: fail");
    end
    $finish;
  end

endmodule
